// File: rtl/core/pbalc_pkg.sv
// Shared types and codes for the paragraph block allocator.
// No dependencies; imported by paragraph_block_allocator.
package pbalc_pkg;

    // header type codes
    localparam logic [1:0] HDR_NONE = 2'd0;
    localparam logic [1:0] HDR_MORE = 2'd1;
    localparam logic [1:0] HDR_LAST = 2'd2;

    // commands
    localparam logic [1:0] CMD_ALLOC     = 2'd0;
    localparam logic [1:0] CMD_FREE      = 2'd1;
    localparam logic [1:0] CMD_RESIZE    = 2'd2;
    localparam logic [1:0] CMD_FREE_OWNR = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_BAD   = 2'd1;
    localparam logic [1:0] ST_NOMEM = 2'd2;

    // fit strategies
    localparam logic [1:0] FIT_FIRST = 2'd0;
    localparam logic [1:0] FIT_BEST  = 2'd1;
    localparam logic [1:0] FIT_LAST  = 2'd2;

    // config register indexes
    localparam logic REG_FIT  = 1'b0;
    localparam logic REG_BASE = 1'b1;

    // one block header as stored
    typedef struct packed {
        logic [1:0]  htype;
        logic [15:0] owner;
        logic [15:0] size;
    } t_hdr;

endpackage

// File: rtl/core/paragraph_block_allocator.sv
// Paragraph block allocator: header chain walker with one header store.
// Depends on pbalc_pkg.
//
// Usage: a command word enters on the input channel (i_in_valid/o_in_stall)
// and gives exactly one result word on the output channel
// (o_out_valid/i_out_stall). Configuration (fit strategy, arena base) is
// written on the cfg channel, which is always ready; the user must write it
// only while the block idles; the block itself does not enforce this.
// One command is in flight at a time; o_in_stall is high while it runs.
// Each header visit is a registered read of the header memory. Allocate
// walks the chain, merging the free blocks that follow each free block;
// free reads one header and clears its owner; allocate adds setup, split
// and write-back; resize, allocate and free-by-owner walk the chain.
// The result sits in an output register, so a stalled receiver holds the
// result while the next command is taken; a finishing command waits there
// only if the previous result is still not taken.
// Reset: a clearing pass writes every header entry, one per cycle,
// leaving one free last block at entry 0; commands are not accepted
// during it.
module paragraph_block_allocator #(
    parameter int ARENA_PARAS = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_command,
    input  logic [15:0] i_para_count,
    input  logic [15:0] i_owner_id,
    input  logic [15:0] i_block_segment,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_granted_segment,
    output logic [15:0] o_largest_free,
    output logic [1:0]  o_status,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import pbalc_pkg::*;

    localparam int AW = (ARENA_PARAS > 1) ? $clog2(ARENA_PARAS) : 1;
    localparam int CW = $clog2(ARENA_PARAS + 1);

    typedef struct packed {
        logic          ok;
        logic [AW-1:0] ix;
    } t_slot;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_DONE, S_W2,
        A_WALK, A_WAIT, A_HDR, A_EVAL, A_NEXT, A_FIN, A_PWAIT, A_PICK,
        M_TEST, M_WAIT, M_CHK,
        F_WAIT, F_CHK,
        R_WAIT, R_CHK, R_TEST, R_WAIT2, R_OWN, R_AFTER, R_END,
        O_WALK, O_WAIT, O_HDR
    } t_state;

    t_state        r_state;
    logic [1:0]    r_cmd;
    logic [15:0]   r_paras, r_own;
    logic [15:0]   r_s;
    logic [CW-1:0] r_n, r_mn;
    logic [15:0]   r_cur_s, r_cur_sz;
    logic [1:0]    r_cur_t;
    logic [15:0]   r_most, r_pick, r_pick_sz;
    logic          r_have;
    logic [15:0]   r_hs, r_avail, r_rown, r_nx;
    logic [1:0]    r_hs_t, r_end_t;
    logic          r_w2_ok;
    logic [AW-1:0] r_w2_ix;
    t_hdr          r_w2_d;
    logic [AW-1:0] r_clr;
    logic [1:0]    r_fit;
    logic [15:0]   r_base;
    logic [15:0]   r_res_gs, r_res_lf;
    logic [1:0]    r_res_st;
    logic          r_out_valid;
    logic [15:0]   r_out_gs, r_out_lf;
    logic [1:0]    r_out_st;

    // header memory port registers
    logic          r_we;
    logic [AW-1:0] r_wa, r_ra;
    t_hdr          r_wd, r_q;
    logic          r_ra_in, r_q_in;
    t_hdr          r_mem [ARENA_PARAS];

    // segment to store slot, with arena bound check
    function automatic t_slot slot_of(input logic [15:0] seg, input logic [15:0] base);
        t_slot       v;
        logic [15:0] d;
        d    = seg - base;
        v.ok = ({1'b0, d} < 17'(ARENA_PARAS));
        v.ix = v.ok ? d[AW-1:0] : '0;
        return v;
    endfunction

    // memory: one write, one registered read with write forwarding
    always_ff @(posedge i_clk) begin
        if (r_we) begin
            r_mem[r_wa] <= r_wd;
        end
        r_q    <= (r_we && r_wa == r_ra) ? r_wd : r_mem[r_ra];
        r_q_in <= r_ra_in;
    end

    // header as seen by the chain: outside the arena reads as foreign
    logic [1:0]  hq_t;
    logic [15:0] hq_own, hq_sz;
    assign hq_t   = r_q_in ? r_q.htype : HDR_NONE;
    assign hq_own = r_q_in ? r_q.owner : 16'hFFFF;
    assign hq_sz  = r_q_in ? r_q.size  : 16'd0;

    assign o_in_stall        = (r_state != S_IDLE);
    assign o_cfg_ready       = 1'b1;
    assign o_out_valid       = r_out_valid;
    assign o_granted_segment = r_out_gs;
    assign o_largest_free    = r_out_lf;
    assign o_status          = r_out_st;

    // sequencer
    always_ff @(posedge i_clk) begin
        t_slot       v_sl;
        logic [15:0] v_a, v_b;
        logic        v_take;
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_we        <= 1'b0;
            r_ra        <= '0;
            r_ra_in     <= 1'b0;
            r_fit       <= FIT_FIRST;
            r_base      <= 16'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_we <= 1'b0;
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                if (i_cfg_index == REG_FIT) begin
                    r_fit <= i_cfg_data[1:0];
                end else begin
                    r_base <= i_cfg_data;
                end
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_we <= 1'b1;
                    r_wa <= r_clr;
                    if (r_clr == '0) begin
                        r_wd <= '{htype: HDR_LAST, owner: 16'd0,
                                  size: 16'(ARENA_PARAS - 1)};
                    end else begin
                        r_wd <= '{htype: HDR_NONE, owner: 16'd0, size: 16'd0};
                    end
                    if (r_clr == AW'(ARENA_PARAS - 1)) begin
                        r_state <= S_IDLE;
                    end
                    r_clr <= r_clr + 1'b1;
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_cmd    <= i_command;
                        r_paras  <= i_para_count;
                        r_own    <= i_owner_id;
                        r_res_gs <= 16'd0;
                        r_res_lf <= 16'd0;
                        r_res_st <= ST_OK;
                        r_s      <= r_base;
                        r_n      <= '0;
                        r_most   <= 16'd0;
                        r_have   <= 1'b0;
                        r_w2_ok  <= 1'b0;
                        v_a      = i_block_segment - 16'd1;
                        r_hs     <= v_a;
                        v_sl     = slot_of(v_a, r_base);
                        unique case (i_command)
                            CMD_ALLOC:     r_state <= A_WALK;
                            CMD_FREE: begin
                                r_ra    <= v_sl.ix;
                                r_ra_in <= v_sl.ok;
                                r_state <= F_WAIT;
                            end
                            CMD_RESIZE: begin
                                r_ra    <= v_sl.ix;
                                r_ra_in <= v_sl.ok;
                                r_state <= R_WAIT;
                            end
                            CMD_FREE_OWNR: r_state <= O_WALK;
                            default:       r_state <= S_IDLE;
                        endcase
                    end
                end
                // ---- allocate walk
                A_WALK: begin
                    v_sl = slot_of(r_s, r_base);
                    if (r_n >= CW'(ARENA_PARAS) || !v_sl.ok) begin
                        r_state <= A_FIN;
                    end else begin
                        r_ra    <= v_sl.ix;
                        r_ra_in <= 1'b1;
                        r_state <= A_WAIT;
                    end
                end
                A_WAIT: r_state <= A_HDR;
                A_HDR: begin
                    r_cur_s  <= r_s;
                    r_cur_t  <= hq_t;
                    r_cur_sz <= hq_sz;
                    r_mn     <= '0;
                    r_state  <= (hq_own == 16'd0) ? M_TEST : A_NEXT;
                end
                A_EVAL: begin
                    if (r_cur_sz > r_most) begin
                        r_most <= r_cur_sz;
                    end
                    r_state <= A_NEXT;
                    if (r_cur_sz >= r_paras) begin
                        v_take = !r_have;
                        if (r_fit == FIT_BEST && r_have) begin
                            v_take = (r_cur_sz < r_pick_sz);
                        end else if (r_fit == FIT_LAST) begin
                            v_take = 1'b1;
                        end
                        if (v_take) begin
                            r_pick    <= r_cur_s;
                            r_pick_sz <= r_cur_sz;
                            r_have    <= 1'b1;
                        end
                        if (r_fit == FIT_FIRST) begin
                            r_state <= A_FIN;
                        end
                    end
                end
                A_NEXT: begin
                    if (r_cur_t == HDR_LAST) begin
                        r_state <= A_FIN;
                    end else begin
                        r_s     <= r_cur_s + 16'd1 + r_cur_sz;
                        r_n     <= r_n + 1'b1;
                        r_state <= A_WALK;
                    end
                end
                A_FIN: begin
                    r_res_lf <= r_most;
                    if (!r_have) begin
                        r_res_st <= ST_NOMEM;
                        r_state  <= S_DONE;
                    end else begin
                        v_sl    = slot_of(r_pick, r_base);
                        r_ra    <= v_sl.ix;
                        r_ra_in <= v_sl.ok;
                        r_state <= A_PWAIT;
                    end
                end
                A_PWAIT: r_state <= A_PICK;
                // claim the picked block, splitting it when it is larger than asked
                A_PICK: begin
                    v_sl = slot_of(r_pick, r_base);
                    r_we <= v_sl.ok;
                    r_wa <= v_sl.ix;
                    if (r_fit == FIT_LAST && r_pick_sz > r_paras) begin
                        v_a = r_pick_sz - r_paras - 16'd1;
                        v_b = r_pick + 16'd1 + v_a;
                        r_wd <= '{htype: HDR_MORE, owner: 16'd0, size: v_a};
                        v_sl = slot_of(v_b, r_base);
                        r_w2_ok  <= v_sl.ok;
                        r_w2_ix  <= v_sl.ix;
                        r_w2_d   <= '{htype: hq_t, owner: r_own, size: r_paras};
                        r_res_gs <= v_b + 16'd1;
                    end else if (r_pick_sz > r_paras) begin
                        v_b = r_pick + 16'd1 + r_paras;
                        r_wd <= '{htype: HDR_MORE, owner: r_own, size: r_paras};
                        v_sl = slot_of(v_b, r_base);
                        r_w2_ok  <= v_sl.ok;
                        r_w2_ix  <= v_sl.ix;
                        r_w2_d   <= '{htype: hq_t, owner: 16'd0,
                                      size: r_pick_sz - r_paras - 16'd1};
                        r_res_gs <= r_pick + 16'd1;
                    end else begin
                        r_wd     <= '{htype: hq_t, owner: r_own, size: hq_sz};
                        r_res_gs <= r_pick + 16'd1;
                    end
                    r_state <= S_W2;
                end
                // ---- merge run of free blocks after r_cur_s
                M_TEST: begin
                    if (r_mn < CW'(ARENA_PARAS) && r_cur_t == HDR_MORE) begin
                        v_sl    = slot_of(r_cur_s + 16'd1 + r_cur_sz, r_base);
                        r_ra    <= v_sl.ix;
                        r_ra_in <= v_sl.ok;
                        r_state <= M_WAIT;
                    end else begin
                        r_state <= (r_cmd == CMD_ALLOC) ? A_EVAL : R_AFTER;
                    end
                end
                M_WAIT: r_state <= M_CHK;
                M_CHK: begin
                    if (hq_own != 16'd0) begin
                        r_state <= (r_cmd == CMD_ALLOC) ? A_EVAL : R_AFTER;
                    end else begin
                        v_a  = r_cur_sz + 16'd1 + hq_sz;
                        v_sl = slot_of(r_cur_s, r_base);
                        r_we     <= v_sl.ok;
                        r_wa     <= v_sl.ix;
                        r_wd     <= '{htype: hq_t, owner: 16'd0, size: v_a};
                        r_cur_t  <= hq_t;
                        r_cur_sz <= v_a;
                        r_mn     <= r_mn + 1'b1;
                        // resize tracks its own header type
                        if (r_cur_s == r_hs) begin
                            r_hs_t <= hq_t;
                        end
                        r_state <= M_TEST;
                    end
                end
                // ---- free block
                F_WAIT: r_state <= F_CHK;
                F_CHK: begin
                    if (r_hs != 16'hFFFF && (hq_t == HDR_MORE || hq_t == HDR_LAST)) begin
                        r_we <= 1'b1;
                        r_wa <= r_ra;
                        r_wd <= '{htype: hq_t, owner: 16'd0, size: hq_sz};
                    end else begin
                        r_res_st <= ST_BAD;
                    end
                    r_state <= S_DONE;
                end
                // ---- resize
                R_WAIT: r_state <= R_CHK;
                R_CHK: begin
                    if (r_hs != 16'hFFFF && (hq_t == HDR_MORE || hq_t == HDR_LAST)) begin
                        r_rown  <= hq_own;
                        r_avail <= hq_sz;
                        r_end_t <= hq_t;
                        r_hs_t  <= hq_t;
                        r_nx    <= r_hs + 16'd1 + hq_sz;
                        r_n     <= '0;
                        r_state <= R_TEST;
                    end else begin
                        r_res_st <= ST_BAD;
                        r_state  <= S_DONE;
                    end
                end
                R_TEST: begin
                    if (r_n < CW'(ARENA_PARAS) && r_hs_t == HDR_MORE) begin
                        v_sl    = slot_of(r_nx, r_base);
                        r_ra    <= v_sl.ix;
                        r_ra_in <= v_sl.ok;
                        r_state <= R_WAIT2;
                    end else begin
                        r_state <= R_END;
                    end
                end
                R_WAIT2: r_state <= R_OWN;
                R_OWN: begin
                    if (hq_own != 16'd0) begin
                        r_state <= R_END;
                    end else begin
                        r_cur_s  <= r_nx;
                        r_cur_t  <= hq_t;
                        r_cur_sz <= hq_sz;
                        r_mn     <= '0;
                        r_state  <= M_TEST;
                    end
                end
                R_AFTER: begin
                    r_avail <= r_avail + 16'd1 + r_cur_sz;
                    r_end_t <= r_cur_t;
                    if (r_cur_t == HDR_LAST) begin
                        r_state <= R_END;
                    end else begin
                        r_nx    <= r_cur_s + 16'd1 + r_cur_sz;
                        r_n     <= r_n + 1'b1;
                        r_state <= R_TEST;
                    end
                end
                R_END: begin
                    v_sl = slot_of(r_hs, r_base);
                    if (r_paras > r_avail) begin
                        r_res_lf <= r_avail;
                        r_res_st <= ST_NOMEM;
                        r_state  <= S_DONE;
                    end else if (r_paras == r_avail) begin
                        r_we    <= v_sl.ok;
                        r_wa    <= v_sl.ix;
                        r_wd    <= '{htype: r_end_t, owner: r_rown, size: r_paras};
                        r_state <= S_DONE;
                    end else begin
                        r_we <= v_sl.ok;
                        r_wa <= v_sl.ix;
                        r_wd <= '{htype: HDR_MORE, owner: r_rown, size: r_paras};
                        v_sl = slot_of(r_hs + 16'd1 + r_paras, r_base);
                        r_w2_ok <= v_sl.ok;
                        r_w2_ix <= v_sl.ix;
                        r_w2_d  <= '{htype: r_end_t, owner: 16'd0,
                                     size: r_avail - r_paras - 16'd1};
                        r_state <= S_W2;
                    end
                end
                // ---- free by owner
                O_WALK: begin
                    v_sl = slot_of(r_s, r_base);
                    if (r_n >= CW'(ARENA_PARAS) || !v_sl.ok) begin
                        r_state <= S_DONE;
                    end else begin
                        r_ra    <= v_sl.ix;
                        r_ra_in <= 1'b1;
                        r_state <= O_WAIT;
                    end
                end
                O_WAIT: r_state <= O_HDR;
                O_HDR: begin
                    if (hq_own == r_own) begin
                        r_we <= 1'b1;
                        r_wa <= r_ra;
                        r_wd <= '{htype: hq_t, owner: 16'd0, size: hq_sz};
                    end
                    if (hq_t == HDR_LAST) begin
                        r_state <= S_DONE;
                    end else begin
                        r_s     <= r_s + 16'd1 + hq_sz;
                        r_n     <= r_n + 1'b1;
                        r_state <= O_WALK;
                    end
                end
                // second header write of a split
                S_W2: begin
                    r_we    <= r_w2_ok;
                    r_wa    <= r_w2_ix;
                    r_wd    <= r_w2_d;
                    r_state <= S_DONE;
                end
                // hand the result word to the output register
                S_DONE: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid <= 1'b1;
                        r_out_gs    <= r_res_gs;
                        r_out_lf    <= r_res_lf;
                        r_out_st    <= r_res_st;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    // an accepted command keeps the block busy on the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("block not busy after accepting a command");

    // only allocate grants a segment, and only with good status
    a_grant_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ST_OK) |-> (o_granted_segment == 16'd0))
        else $error("segment granted with failing status");

    // status stays within its codes
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status == ST_OK || o_status == ST_BAD || o_status == ST_NOMEM))
        else $error("bad status code");
`endif

endmodule

// File: verif/paragraph_block_allocator_test.sv
// Self-checking testbench for paragraph_block_allocator: directed and random commands,
// each result checked against a header chain model or typed results. Depends on pbalc_pkg.
`timescale 1ns / 1ps

module paragraph_block_allocator_test;
    import pbalc_pkg::*;

    localparam int ARENA   = 4096;
    localparam int WD_MAX  = 200000;
    localparam int N_PHASE = 6;
    localparam int PER_PHASE = 335;

    typedef struct packed {
        logic [15:0] granted;
        logic [15:0] largest;
        logic [1:0]  status;
    } t_res;

    typedef struct {
        logic [1:0]  cmd;
        logic [15:0] paras;
        logic [15:0] owner;
        logic [15:0] seg;
        bit          typed;
        t_res        res;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [1:0]  i_command = CMD_ALLOC;
    logic [15:0] i_para_count = '0;
    logic [15:0] i_owner_id = '0;
    logic [15:0] i_block_segment = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [15:0] o_granted_segment;
    logic [15:0] o_largest_free;
    logic [1:0]  o_status;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_index = REG_FIT;
    logic [15:0] i_cfg_data = '0;

    paragraph_block_allocator #(.ARENA_PARAS(ARENA)) DUT (.*);

    always #2 i_clk = ~i_clk;

    // model state of the header chain
    logic [1:0]  hdr_type  [ARENA];
    logic [15:0] hdr_owner [ARENA];
    logic [15:0] hdr_size  [ARENA];
    logic [1:0]  fit_mode = FIT_FIRST;
    logic [15:0] arena_base = '0;

    t_res        pending_results[$];
    logic [15:0] live_segs[$];
    bit          any_fail = 1'b0;
    int          snd_pct = 0;
    int          rcv_pct = 0;
    int          quiet_cycles = 0;

    function automatic bit slot_of(logic [15:0] s, output int ix);
        logic [15:0] d;
        d = s - arena_base;
        ix = int'(d);
        return d < ARENA;
    endfunction

    function automatic logic [1:0] type_at(logic [15:0] s);
        int i;
        return slot_of(s, i) ? hdr_type[i] : HDR_NONE;
    endfunction

    function automatic logic [15:0] owner_at(logic [15:0] s);
        int i;
        return slot_of(s, i) ? hdr_owner[i] : 16'hFFFF;
    endfunction

    function automatic logic [15:0] size_at(logic [15:0] s);
        int i;
        return slot_of(s, i) ? hdr_size[i] : 16'd0;
    endfunction

    function automatic void put_hdr(logic [15:0] s, logic [1:0] t, logic [15:0] own,
                                    logic [15:0] sz);
        int i;
        if (slot_of(s, i)) begin
            hdr_type[i] = t;
            hdr_owner[i] = own;
            hdr_size[i] = sz;
        end
    endfunction

    function automatic void put_owner(logic [15:0] s, logic [15:0] own);
        int i;
        if (slot_of(s, i)) hdr_owner[i] = own;
    endfunction

    function automatic logic [15:0] next_of(logic [15:0] s);
        return s + 16'd1 + size_at(s);
    endfunction

    // coalesce the run of free blocks following s into s
    function automatic void merge_run(logic [15:0] s);
        logic [15:0] nx;
        for (int n = 0; n < ARENA && type_at(s) == HDR_MORE; n++) begin
            nx = next_of(s);
            if (owner_at(nx) != 0) break;
            put_hdr(s, type_at(nx), 16'd0, size_at(s) + 16'd1 + size_at(nx));
        end
    endfunction

    function automatic bit header_ok(logic [15:0] seg);
        logic [1:0] t;
        t = type_at(seg - 16'd1);
        return seg != 0 && (t == HDR_MORE || t == HDR_LAST);
    endfunction

    function automatic t_res alloc_blocks(logic [15:0] paras, logic [15:0] own);
        logic [15:0] s, pick, pick_sz, most, sz, lead;
        logic [1:0]  t;
        bit          have, take;
        int          ix;
        t_res        r;
        s = arena_base; pick = '0; pick_sz = '0; most = '0; have = 1'b0;
        r = '0;
        for (int n = 0; n < ARENA && slot_of(s, ix); n++) begin
            if (owner_at(s) == 0) begin
                merge_run(s);
                sz = size_at(s);
                if (sz > most) most = sz;
                if (sz >= paras) begin
                    take = !have;
                    if (fit_mode == FIT_BEST && have) take = sz < pick_sz;
                    else if (fit_mode == FIT_LAST) take = 1'b1;
                    if (take) begin
                        pick = s; pick_sz = sz; have = 1'b1;
                    end
                    if (fit_mode == FIT_FIRST) break;
                end
            end
            if (type_at(s) == HDR_LAST) break;
            s = next_of(s);
        end
        r.largest = most;
        if (!have) begin
            r.status = ST_NOMEM;
            return r;
        end
        t = type_at(pick);
        if (fit_mode == FIT_LAST && pick_sz > paras) begin
            // carve from the top, free remainder stays below
            lead = pick_sz - paras - 16'd1;
            put_hdr(pick, HDR_MORE, 16'd0, lead);
            pick = pick + 16'd1 + lead;
            put_hdr(pick, t, own, paras);
        end else if (pick_sz > paras) begin
            put_hdr(pick, HDR_MORE, own, paras);
            put_hdr(pick + 16'd1 + paras, t, 16'd0, pick_sz - paras - 16'd1);
        end else begin
            put_owner(pick, own);
        end
        r.granted = pick + 16'd1;
        r.status = ST_OK;
        return r;
    endfunction

    function automatic t_res resize_block(logic [15:0] seg, logic [15:0] paras);
        logic [15:0] s, own, avail, nx;
        logic [1:0]  end_t;
        t_res        r;
        r = '0;
        s = seg - 16'd1;
        if (!header_ok(seg)) begin
            r.status = ST_BAD;
            return r;
        end
        own = owner_at(s);
        avail = size_at(s);
        end_t = type_at(s);
        nx = s + 16'd1 + avail;
        for (int n = 0; n < ARENA && type_at(s) == HDR_MORE && owner_at(nx) == 0; n++) begin
            merge_run(nx);
            avail = avail + 16'd1 + size_at(nx);
            end_t = type_at(nx);
            if (end_t == HDR_LAST) break;
            nx = next_of(nx);
        end
        if (paras > avail) begin
            r.largest = avail;
            r.status = ST_NOMEM;
            return r;
        end
        if (paras == avail) begin
            put_hdr(s, end_t, own, paras);
        end else begin
            put_hdr(s, HDR_MORE, own, paras);
            put_hdr(s + 16'd1 + paras, end_t, 16'd0, avail - paras - 16'd1);
        end
        r.status = ST_OK;
        return r;
    endfunction

    function automatic void release_owner(logic [15:0] own);
        logic [15:0] s;
        int ix;
        s = arena_base;
        for (int n = 0; n < ARENA && slot_of(s, ix); n++) begin
            if (owner_at(s) == own) put_owner(s, 16'd0);
            if (type_at(s) == HDR_LAST) break;
            s = next_of(s);
        end
    endfunction

    function automatic t_res predict_command(logic [1:0] cmd, logic [15:0] paras,
                                             logic [15:0] own, logic [15:0] seg);
        t_res r;
        r = '0;
        case (cmd)
            CMD_ALLOC:  r = alloc_blocks(paras, own);
            CMD_FREE: begin
                if (!header_ok(seg)) r.status = ST_BAD;
                else put_owner(seg - 16'd1, 16'd0);
            end
            CMD_RESIZE: r = resize_block(seg, paras);
            default:    release_owner(own);
        endcase
        return r;
    endfunction

    // present one command word, hold it until taken, then log the expectation
    task automatic send_command(logic [1:0] cmd, logic [15:0] paras, logic [15:0] own,
                                logic [15:0] seg, bit typed, t_res typed_res);
        t_res r;
        while ($urandom_range(0, 99) < snd_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_command <= cmd;
        i_para_count <= paras;
        i_owner_id <= own;
        i_block_segment <= seg;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        r = predict_command(cmd, paras, own, seg);
        if (typed) r = typed_res;
        pending_results.push_back(r);
        if (cmd == CMD_ALLOC && r.status == ST_OK) begin
            live_segs.push_back(r.granted);
            if (live_segs.size() > 48) void'(live_segs.pop_front());
        end
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // one register write; ends in the cycle after the handshake
    task automatic write_reg(logic idx, logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        if (idx == REG_FIT) fit_mode = data[1:0];
        else arena_base = data;
        @(posedge i_clk);
    endtask

    // receiver stall pattern
    always @(posedge i_clk) i_out_stall <= ($urandom_range(0, 99) < rcv_pct);

    // result checker
    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result word g=%h lf=%h st=%0d", $time,
                         o_granted_segment, o_largest_free, o_status);
                any_fail = 1'b1;
            end else begin
                want = pending_results.pop_front();
                if (o_granted_segment !== want.granted) begin
                    $display("%0t: granted_segment expected %h actual %h", $time,
                             want.granted, o_granted_segment);
                    any_fail = 1'b1;
                end
                if (o_largest_free !== want.largest) begin
                    $display("%0t: largest_free expected %h actual %h", $time,
                             want.largest, o_largest_free);
                    any_fail = 1'b1;
                end
                if (o_status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d", $time,
                             want.status, o_status);
                    any_fail = 1'b1;
                end
            end
        end
    end

    // watchdog on cycles with no handshake at all
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WD_MAX) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // directed rows; typed results are plain after-reset or error cases
    t_row directed[] = '{
        '{CMD_ALLOC,     16'd16,    16'd1,     16'd0,     1, '{16'd1, 16'd4095, ST_OK}},
        '{CMD_FREE,      16'd0,     16'd0,     16'd0,     1, '{16'd0, 16'd0, ST_BAD}},
        '{CMD_FREE,      16'd0,     16'd0,     16'd5,     1, '{16'd0, 16'd0, ST_BAD}},
        '{CMD_ALLOC,     16'hFFFF,  16'hFFFF,  16'd0,     1, '{16'd0, 16'd4078, ST_NOMEM}},
        '{CMD_ALLOC,     16'd0,     16'd2,     16'd0,     0, '{16'd0, 16'd0, ST_OK}},
        '{CMD_ALLOC,     16'd100,   16'hFFFF,  16'd0,     0, '{16'd0, 16'd0, ST_OK}},
        '{CMD_RESIZE,    16'd8,     16'd0,     16'd1,     0, '{16'd0, 16'd0, ST_OK}},
        '{CMD_RESIZE,    16'hFFFF,  16'd0,     16'd1,     0, '{16'd0, 16'd0, ST_OK}},
        '{CMD_RESIZE,    16'd16,    16'd0,     16'd1,     0, '{16'd0, 16'd0, ST_OK}},
        '{CMD_FREE,      16'd0,     16'd0,     16'd1,     0, '{16'd0, 16'd0, ST_OK}},
        '{CMD_ALLOC,     16'd8,     16'd3,     16'd0,     0, '{16'd0, 16'd0, ST_OK}},
        '{CMD_FREE_OWNR, 16'd0,     16'hFFFF,  16'd0,     0, '{16'd0, 16'd0, ST_OK}},
        '{CMD_FREE_OWNR, 16'd0,     16'd2,     16'd0,     0, '{16'd0, 16'd0, ST_OK}},
        '{CMD_ALLOC,     16'hAAAA,  16'h5555,  16'd0,     0, '{16'd0, 16'd0, ST_OK}},
        '{CMD_ALLOC,     16'h0555,  16'hAAAA,  16'd0,     0, '{16'd0, 16'd0, ST_OK}},
        '{CMD_RESIZE,    16'd0,     16'd0,     16'hFFFF,  1, '{16'd0, 16'd0, ST_BAD}},
        '{CMD_RESIZE,    16'd0,     16'd0,     16'd0,     1, '{16'd0, 16'd0, ST_BAD}},
        '{CMD_FREE_OWNR, 16'd0,     16'd0,     16'd0,     0, '{16'd0, 16'd0, ST_OK}},
        '{CMD_ALLOC,     16'd4000,  16'd7,     16'd0,     0, '{16'd0, 16'd0, ST_OK}},
        '{CMD_FREE_OWNR, 16'd0,     16'd3,     16'd0,     0, '{16'd0, 16'd0, ST_OK}}
    };

    // per-phase settings, extremes included
    logic [1:0]  phase_fit [N_PHASE] = '{FIT_BEST, FIT_LAST, 2'd3, FIT_FIRST, FIT_LAST, FIT_BEST};
    logic [15:0] phase_base[N_PHASE] = '{16'hFFFF, 16'h1234, 16'hF800, 16'h8000, 16'h0000,
                                         16'h00FF};

    initial begin
        logic [1:0]  cmd;
        logic [15:0] paras, own, seg;
        int          roll;
        for (int i = 0; i < ARENA; i++) begin
            hdr_type[i] = HDR_NONE;
            hdr_owner[i] = '0;
            hdr_size[i] = '0;
        end
        hdr_type[0] = HDR_LAST;
        hdr_size[0] = 16'(ARENA - 1);
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        snd_pct = 27;
        rcv_pct = 60;
        foreach (directed[k])
            send_command(directed[k].cmd, directed[k].paras, directed[k].owner,
                         directed[k].seg, directed[k].typed, directed[k].res);

        for (int ph = 0; ph < N_PHASE; ph++) begin
            // sender holds off until the block is empty before reconfiguring
            drain_results();
            write_reg(REG_FIT, {14'd0, phase_fit[ph]});
            write_reg(REG_BASE, phase_base[ph]);
            live_segs.delete();
            case (ph / 2)
                0: begin snd_pct = 27; rcv_pct = 60; end
                1: begin snd_pct = 60; rcv_pct = 27; end
                default: begin snd_pct = 0; rcv_pct = 0; end
            endcase
            for (int n = 0; n < PER_PHASE; n++) begin
                roll = $urandom_range(0, 99);
                if (roll < 42) cmd = CMD_ALLOC;
                else if (roll < 70) cmd = CMD_FREE;
                else if (roll < 92) cmd = CMD_RESIZE;
                else cmd = CMD_FREE_OWNR;
                paras = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(0, 65535))
                                                    : 16'($urandom_range(0, 48));
                own = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 65535))
                                                  : 16'($urandom_range(1, 6));
                if (live_segs.size() != 0 && $urandom_range(0, 9) < 8)
                    seg = live_segs[$urandom_range(0, live_segs.size() - 1)];
                else if ($urandom_range(0, 1) == 0)
                    seg = 16'($urandom_range(0, 65535));
                else
                    seg = arena_base + 16'($urandom_range(0, 64));
                send_command(cmd, paras, own, seg, 1'b0, '0);
            end
        end

        drain_results();
        repeat (40) @(posedge i_clk);
        if (!any_fail && pending_results.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule

// File: paragraph_block_allocator.f
rtl/core/pbalc_pkg.sv
rtl/core/paragraph_block_allocator.sv
verif/paragraph_block_allocator_test.sv
